// File: rtl/scd_pkg.sv
package scd_pkg;

  localparam int TAIL_BYTES   = 4;
  localparam int COUNT_BITS   = 32;
  localparam int QUEUE_DEPTH  = 4;

  // result kinds
  localparam logic [1:0] KIND_NAME   = 2'd0;
  localparam logic [1:0] KIND_CODE   = 2'd1;
  localparam logic [1:0] KIND_FIELD  = 2'd2;
  localparam logic [1:0] KIND_STATUS = 2'd3;

  // frame status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_SHORT    = 3'd1;
  localparam logic [2:0] ST_MAGIC    = 3'd2;
  localparam logic [2:0] ST_FLAG     = 3'd3;
  localparam logic [2:0] ST_CHECKSUM = 3'd4;
  localparam logic [2:0] ST_OVERFLOW = 3'd5;
  localparam logic [2:0] ST_ORPHAN   = 3'd6;
  localparam logic [2:0] ST_TRAILER  = 3'd7;

  localparam logic [7:0]  MAGIC_LO     = 8'h4E;  // 'N'
  localparam logic [7:0]  MAGIC_HI     = 8'h53;  // 'S'
  localparam logic [15:0] FLAG_WORD    = 16'hFFFF;
  localparam logic [15:0] SEG_MARK     = 16'hA5A5;
  localparam logic [15:0] CODE_MARK    = 16'hAAAA;
  localparam logic [15:0] TRAILER_WORD = 16'hFFFF;
  localparam int HDR_BYTES     = 12;
  localparam int CONTENT_START = 16;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  item_kind;
    logic [15:0] slot_index;
    logic [15:0] item_value;
    logic [2:0]  frame_status;
    logic        out_last;
  } out_item_t;

  // results caused by one input beat: first item, optional second item
  typedef struct packed {
    out_item_t a;
    logic      b_valid;
    out_item_t b;
  } bundle_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// File: rtl/segment_container_deframer.sv
// A result goes through the queue and then the output register before it is offered.
// Throughput: one beat per cycle unless the queue is full; one result per cycle leaves
// the output register while out_ready is high. A beat gives at most two results (the
// final beat may add the status), kept in one entry of the 4-entry parser-output queue.
// Reset (rst_n low, synchronous): parser state, queue pointers and output valid clear.
// After each final-status beat the parser returns to its reset state by itself.
module segment_container_deframer #(
  parameter int COUNT_BITS = scd_pkg::COUNT_BITS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  scd_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output scd_pkg::out_item_t out_data
);

  logic             q_push;
  logic             q_pop;
  scd_pkg::bundle_t q_wdata;
  scd_pkg::bundle_t q_head;
  scd_pkg::q_stat_t q_stat;

  scd_front #(
    .COUNT_BITS(COUNT_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_stat   (q_stat),
    .q_push   (q_push),
    .q_data   (q_wdata)
  );

  scd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .pop       (q_pop),
    .head      (q_head),
    .stat      (q_stat)
  );

  scd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (q_head),
    .q_stat    (q_stat),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // a final beat always leaves a status result in the queue
  a_last_pushes: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_data.in_last) |-> q_push)
    else $error("final beat accepted without queue push");

  a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_stat.full)
    else $error("push into full queue");

  a_status_only_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.item_kind != scd_pkg::KIND_STATUS) |->
      (!out_data.out_last && out_data.frame_status == scd_pkg::ST_OK))
    else $error("non-status result carries status or last");

  a_pop_when_data: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_stat.empty)
    else $error("pop from empty queue");

endmodule

// File: rtl/scd_front.sv
module scd_front #(
  parameter int COUNT_BITS = scd_pkg::COUNT_BITS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  scd_pkg::in_item_t in_data,
  input  scd_pkg::q_stat_t  q_stat,
  output logic              q_push,
  output scd_pkg::bundle_t  q_data
);

  localparam logic [COUNT_BITS-1:0] N_HDR    = COUNT_BITS'(scd_pkg::HDR_BYTES);
  localparam logic [COUNT_BITS-1:0] N_START  = COUNT_BITS'(scd_pkg::CONTENT_START);
  localparam logic [COUNT_BITS-1:0] N_SHORT  = COUNT_BITS'(scd_pkg::CONTENT_START - 1);
  localparam logic [COUNT_BITS-1:0] N_MAGIC  = COUNT_BITS'(1);
  localparam logic [COUNT_BITS-1:0] N_FLAG   = COUNT_BITS'(3);
  localparam logic [COUNT_BITS-1:0] N_FIELD0 = COUNT_BITS'(5);
  localparam logic [COUNT_BITS-1:0] N_SEGCNT = COUNT_BITS'(11);
  localparam int TB = scd_pkg::TAIL_BYTES;

  logic [7:0]            tail_r [TB];
  logic [7:0]            tail_nxt [TB];
  logic [COUNT_BITS-1:0] count_r, count_nxt;
  logic [15:0]           sum_r, sum_nxt;
  logic [15:0]           total_r, total_nxt;
  logic [15:0]           cur_r, cur_nxt;
  logic                  opened_r, opened_nxt;
  logic                  code_r, code_nxt;
  logic                  skip_r, skip_nxt;
  logic [2:0]            err_r, err_nxt;
  logic [7:0]            low_r, low_nxt;

  logic                  accept;
  logic [7:0]            b;
  logic [15:0]           word;
  logic [15:0]           mark;
  logic [16:0]           opened_cnt;
  logic [3:0]            n_off;
  logic [15:0]           csum;
  logic [15:0]           expect_w;
  logic [15:0]           trailer;
  logic [2:0]            status;
  logic                  prim_valid;
  scd_pkg::out_item_t    prim, stat_item;

  assign in_ready = !q_stat.full;
  assign accept   = in_valid && !q_stat.full;
  assign b        = in_data.in_byte;
  assign word     = {b, low_r};
  assign mark     = {tail_r[TB-2], tail_r[TB-1]};
  assign n_off    = count_r[3:0] - 4'd5;

  always_comb begin
    count_nxt  = count_r;
    sum_nxt    = sum_r;
    total_nxt  = total_r;
    cur_nxt    = cur_r;
    opened_nxt = opened_r;
    code_nxt   = code_r;
    skip_nxt   = skip_r;
    err_nxt    = err_r;
    low_nxt    = low_r;
    for (int i = 0; i < TB; i++) tail_nxt[i] = tail_r[i];
    prim_valid = 1'b0;
    prim       = '0;
    opened_cnt = opened_r ? ({1'b0, cur_r} + 17'd1) : 17'd0;

    // header words
    if (count_r < N_HDR) begin
      if (!count_r[0]) begin
        low_nxt = b;
      end else begin
        if (count_r == N_MAGIC && !(low_r == scd_pkg::MAGIC_LO && b == scd_pkg::MAGIC_HI)
            && err_nxt == scd_pkg::ST_OK)
          err_nxt = scd_pkg::ST_MAGIC;
        if (count_r == N_FLAG && word != scd_pkg::FLAG_WORD && err_nxt == scd_pkg::ST_OK)
          err_nxt = scd_pkg::ST_FLAG;
        if (count_r >= N_FIELD0) begin
          prim_valid      = 1'b1;
          prim.item_kind  = scd_pkg::KIND_FIELD;
          prim.slot_index = {14'd0, n_off[2:1]};
          prim.item_value = word;
          if (count_r == N_SEGCNT) total_nxt = word;
        end
      end
    end

    // classify the byte that just left the tail window
    if (count_r >= N_START) begin
      if (skip_r) begin
        skip_nxt = 1'b0;
      end else if (err_r == scd_pkg::ST_OK) begin
        if (mark == scd_pkg::SEG_MARK) begin
          if (opened_cnt >= {1'b0, total_r}) begin
            err_nxt = scd_pkg::ST_OVERFLOW;
          end else begin
            if (opened_r) cur_nxt = cur_r + 16'd1;
            opened_nxt = 1'b1;
            code_nxt   = 1'b0;
            skip_nxt   = 1'b1;
          end
        end else if (mark == scd_pkg::CODE_MARK) begin
          if (!opened_r) begin
            err_nxt = scd_pkg::ST_ORPHAN;
          end else begin
            code_nxt = 1'b1;
            skip_nxt = 1'b1;
          end
        end else if (!opened_r) begin
          err_nxt = scd_pkg::ST_ORPHAN;
        end else begin
          prim_valid      = 1'b1;
          prim.item_kind  = code_r ? scd_pkg::KIND_CODE : scd_pkg::KIND_NAME;
          prim.slot_index = cur_r;
          prim.item_value = {8'd0, tail_r[TB-1]};
        end
      end
    end

    // final status, from state after this beat's classification
    csum     = sum_r - {8'd0, tail_r[0]};
    expect_w = {b, tail_r[0]};
    trailer  = skip_nxt ? {tail_r[0], tail_r[1]} : {tail_r[1], tail_r[2]};
    if (count_r < N_SHORT)
      status = scd_pkg::ST_SHORT;
    else if (err_nxt == scd_pkg::ST_MAGIC || err_nxt == scd_pkg::ST_FLAG)
      status = err_nxt;
    else if (csum != expect_w)
      status = scd_pkg::ST_CHECKSUM;
    else if (err_nxt != scd_pkg::ST_OK)
      status = err_nxt;
    else if (trailer != scd_pkg::TRAILER_WORD)
      status = scd_pkg::ST_TRAILER;
    else
      status = scd_pkg::ST_OK;

    if (in_data.in_last) begin
      count_nxt  = '0;
      sum_nxt    = '0;
      total_nxt  = '0;
      cur_nxt    = '0;
      opened_nxt = 1'b0;
      code_nxt   = 1'b0;
      skip_nxt   = 1'b0;
      err_nxt    = scd_pkg::ST_OK;
      low_nxt    = '0;
      for (int i = 0; i < TB; i++) tail_nxt[i] = '0;
    end else begin
      for (int i = TB - 1; i > 0; i--) tail_nxt[i] = tail_r[i-1];
      tail_nxt[0] = b;
      sum_nxt     = sum_r + {8'd0, b};
      if (count_r != '1) count_nxt = count_r + COUNT_BITS'(1);
    end
  end

  always_comb begin
    stat_item              = '0;
    stat_item.item_kind    = scd_pkg::KIND_STATUS;
    stat_item.frame_status = status;
    stat_item.out_last     = 1'b1;
    q_data                 = '0;
    if (prim_valid) begin
      q_data.a       = prim;
      q_data.b_valid = in_data.in_last;
      q_data.b       = stat_item;
    end else begin
      q_data.a       = stat_item;
    end
  end

  assign q_push = accept && (prim_valid || in_data.in_last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      sum_r    <= '0;
      total_r  <= '0;
      cur_r    <= '0;
      opened_r <= 1'b0;
      code_r   <= 1'b0;
      skip_r   <= 1'b0;
      err_r    <= scd_pkg::ST_OK;
      low_r    <= '0;
      for (int i = 0; i < TB; i++) tail_r[i] <= '0;
    end else if (accept) begin
      count_r  <= count_nxt;
      sum_r    <= sum_nxt;
      total_r  <= total_nxt;
      cur_r    <= cur_nxt;
      opened_r <= opened_nxt;
      code_r   <= code_nxt;
      skip_r   <= skip_nxt;
      err_r    <= err_nxt;
      low_r    <= low_nxt;
      for (int i = 0; i < TB; i++) tail_r[i] <= tail_nxt[i];
    end
  end

endmodule

// File: rtl/scd_queue.sv
module scd_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  scd_pkg::bundle_t push_data,
  input  logic             pop,
  output scd_pkg::bundle_t head,
  output scd_pkg::q_stat_t stat
);

  localparam int DEPTH = scd_pkg::QUEUE_DEPTH;
  localparam int PW    = $clog2(DEPTH);

  scd_pkg::bundle_t mem [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [PW:0]      cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign stat.full  = (cnt_r == (PW+1)'(DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head       = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    if (do_pop)  rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    if (do_push && !do_pop)      cnt_nxt = cnt_r + (PW+1)'(1);
    else if (do_pop && !do_push) cnt_nxt = cnt_r - (PW+1)'(1);
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// File: rtl/scd_back.sv
module scd_back (
  input  logic               clk,
  input  logic               rst_n,
  input  scd_pkg::bundle_t   head,
  input  scd_pkg::q_stat_t   q_stat,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output scd_pkg::out_item_t out_data
);

  logic               valid_r, valid_nxt;
  logic               second_r, second_nxt;  // head's second item still to send
  scd_pkg::out_item_t data_r, data_nxt;
  logic               load;

  assign load      = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_comb begin
    valid_nxt  = valid_r;
    second_nxt = second_r;
    data_nxt   = data_r;
    pop        = 1'b0;
    if (load) begin
      if (second_r) begin
        valid_nxt  = 1'b1;
        data_nxt   = head.b;
        second_nxt = 1'b0;
        pop        = 1'b1;
      end else if (!q_stat.empty) begin
        valid_nxt = 1'b1;
        data_nxt  = head.a;
        if (head.b_valid) second_nxt = 1'b1;
        else              pop        = 1'b1;
      end else begin
        valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= 1'b0;
      second_r <= 1'b0;
    end else begin
      valid_r  <= valid_nxt;
      second_r <= second_nxt;
    end
  end

endmodule

// File: tb/sv/scd_checker.sv
module scd_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  scd_pkg::in_item_t  in_data,
  input  logic               out_valid,
  input  logic               out_ready,
  input  scd_pkg::out_item_t out_data,
  output int                 fail_count,
  output int                 pending,
  output int                 images_done,
  output int                 images_ok,
  output int                 results_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  // parser mirror
  logic [7:0]  recent [0:3];   // [0] newest byte
  logic [31:0] nbytes;
  logic [15:0] sum16;
  logic [15:0] seg_limit;
  logic [15:0] seg_idx;
  logic        seg_open;
  logic        code_part;
  logic        mark_skip;
  logic [2:0]  err_code;
  logic [7:0]  word_lo;

  scd_pkg::out_item_t predicted_items[$];

  task automatic clear_parser();
    for (int i = 0; i < 4; i++) recent[i] = 8'h00;
    nbytes    = '0;
    sum16     = '0;
    seg_limit = '0;
    seg_idx   = '0;
    seg_open  = 1'b0;
    code_part = 1'b0;
    mark_skip = 1'b0;
    err_code  = scd_pkg::ST_OK;
    word_lo   = '0;
  endtask

  task automatic flag_first(input logic [2:0] code);
    if (err_code == scd_pkg::ST_OK) err_code = code;
  endtask

  task automatic add_result(input logic [1:0] kind, input logic [15:0] slot,
                            input logic [15:0] value, input logic [2:0] status,
                            input logic last);
    scd_pkg::out_item_t r;
    r.item_kind    = kind;
    r.slot_index   = slot;
    r.item_value   = value;
    r.frame_status = status;
    r.out_last     = last;
    predicted_items.insert(predicted_items.size(), r);
  endtask

  task automatic parse_byte(input logic [7:0] b, input logic last);
    logic [31:0] n;
    logic [15:0] word;
    logic [15:0] w;
    logic [16:0] opened;
    logic [15:0] body_sum;
    logic [15:0] stored_sum;
    logic [15:0] trailer;
    logic [2:0]  status;
    n = nbytes;

    if (n < scd_pkg::HDR_BYTES) begin
      if (!n[0]) begin
        word_lo = b;
      end else begin
        word = {b, word_lo};
        if (n == 1 && !(word_lo == scd_pkg::MAGIC_LO && b == scd_pkg::MAGIC_HI))
          flag_first(scd_pkg::ST_MAGIC);
        if (n == 3 && word != scd_pkg::FLAG_WORD) flag_first(scd_pkg::ST_FLAG);
        if (n >= 5) begin
          add_result(scd_pkg::KIND_FIELD, 16'((n - 5) >> 1), word, scd_pkg::ST_OK, 1'b0);
          if (n == 11) seg_limit = word;
        end
      end
    end

    // the byte four positions back is now safe to classify
    if (n >= scd_pkg::CONTENT_START) begin
      if (mark_skip) begin
        mark_skip = 1'b0;
      end else if (err_code == scd_pkg::ST_OK) begin
        w = {recent[2], recent[3]};
        if (w == scd_pkg::SEG_MARK) begin
          opened = seg_open ? {1'b0, seg_idx} + 17'd1 : 17'd0;
          if (opened >= {1'b0, seg_limit}) begin
            flag_first(scd_pkg::ST_OVERFLOW);
          end else begin
            if (seg_open) seg_idx = seg_idx + 16'd1;
            seg_open  = 1'b1;
            code_part = 1'b0;
            mark_skip = 1'b1;
          end
        end else if (w == scd_pkg::CODE_MARK) begin
          if (!seg_open) begin
            flag_first(scd_pkg::ST_ORPHAN);
          end else begin
            code_part = 1'b1;
            mark_skip = 1'b1;
          end
        end else if (!seg_open) begin
          flag_first(scd_pkg::ST_ORPHAN);
        end else begin
          add_result(code_part ? scd_pkg::KIND_CODE : scd_pkg::KIND_NAME, seg_idx,
                     {8'h00, recent[3]}, scd_pkg::ST_OK, 1'b0);
        end
      end
    end

    if (last) begin
      if (n < 15) begin
        status = scd_pkg::ST_SHORT;
      end else if (err_code == scd_pkg::ST_MAGIC || err_code == scd_pkg::ST_FLAG) begin
        status = err_code;
      end else begin
        body_sum   = sum16 - {8'h00, recent[0]};
        stored_sum = {b, recent[0]};
        trailer    = mark_skip ? {recent[0], recent[1]} : {recent[1], recent[2]};
        if (body_sum != stored_sum)                status = scd_pkg::ST_CHECKSUM;
        else if (err_code != scd_pkg::ST_OK)       status = err_code;
        else if (trailer != scd_pkg::TRAILER_WORD) status = scd_pkg::ST_TRAILER;
        else                                       status = scd_pkg::ST_OK;
      end
      add_result(scd_pkg::KIND_STATUS, 16'h0000, 16'h0000, status, 1'b1);
      clear_parser();
    end else begin
      recent[3] = recent[2];
      recent[2] = recent[1];
      recent[1] = recent[0];
      recent[0] = b;
      sum16 = sum16 + {8'h00, b};
      if (nbytes != '1) nbytes = nbytes + 32'd1;
    end
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    scd_pkg::out_item_t want;
    if (!rst_n) begin
      clear_parser();
      predicted_items.delete();
      fail_count   = 0;
      images_done  = 0;
      images_ok    = 0;
      results_seen = 0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (predicted_items.size() == 0) begin
          $error("result beat with nothing expected: kind %0d slot %0h value %0h",
                 out_data.item_kind, out_data.slot_index, out_data.item_value);
          fail_count++;
        end else begin
          want = predicted_items.pop_front();
          check_field("item_kind", {14'h0, want.item_kind}, {14'h0, out_data.item_kind});
          check_field("slot_index", want.slot_index, out_data.slot_index);
          check_field("item_value", want.item_value, out_data.item_value);
          check_field("frame_status", {13'h0, want.frame_status},
                      {13'h0, out_data.frame_status});
          check_field("out_last", {15'h0, want.out_last}, {15'h0, out_data.out_last});
          if (want.item_kind == scd_pkg::KIND_STATUS) begin
            images_done++;
            if (want.frame_status == scd_pkg::ST_OK) images_ok++;
          end
        end
      end
      if (in_valid && in_ready) parse_byte(in_data.in_byte, in_data.in_last);
    end
    pending = predicted_items.size();
  end

endmodule

// File: tb/sv/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int BYTE_TARGET = 430;
  localparam int IDLE_LIMIT  = 2000;
  localparam int DRAIN_TAIL  = 20;

  typedef enum int {
    FLAW_NONE, FLAW_SHORT, FLAW_MAGIC, FLAW_FLAG, FLAW_CHECKSUM,
    FLAW_OVERFLOW, FLAW_ORPHAN, FLAW_TRAILER, FLAW_NOISE
  } flaw_e;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  scd_pkg::in_item_t  in_data;
  logic               out_valid;
  logic               out_ready;
  scd_pkg::out_item_t out_data;

  int fail_count, pending, images_done, images_ok, results_seen;
  int bytes_sent;
  int idle_cycles = 0;
  bit tx_fast;
  bit rx_fast;

  logic [7:0] img[$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  segment_container_deframer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  scd_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data),
    .fail_count   (fail_count),
    .pending      (pending),
    .images_done  (images_done),
    .images_ok    (images_ok),
    .results_seen (results_seen)
  );

  // mostly keeps marker bytes out of segment content, but not always
  function automatic logic [7:0] content_byte();
    logic [7:0] v;
    v = 8'($urandom);
    if ((v == scd_pkg::SEG_MARK[7:0] || v == scd_pkg::CODE_MARK[7:0]) &&
        $urandom_range(0, 7) != 0)
      v = v ^ 8'h01;
    return v;
  endfunction

  task automatic append_byte(input logic [7:0] v);
    img.insert(img.size(), v);
  endtask

  task automatic push_word(input logic [15:0] w);
    append_byte(w[7:0]);
    append_byte(w[15:8]);
  endtask

  task automatic build_image(input flaw_e flaw);
    int nseg;
    int len;
    int k;
    logic [15:0] seg_field;
    logic [15:0] csum;
    img.delete();
    if (flaw == FLAW_SHORT || flaw == FLAW_NOISE) begin
      len = (flaw == FLAW_SHORT) ? $urandom_range(1, 15) : $urandom_range(16, 40);
      repeat (len) append_byte(8'($urandom));
      return;
    end
    nseg = $urandom_range(0, 3);
    if (flaw == FLAW_OVERFLOW && nseg == 0) nseg = 1;
    if (flaw == FLAW_OVERFLOW)
      seg_field = 16'(nseg - 1);
    else if ($urandom_range(0, 3) == 0)
      seg_field = 16'(nseg + $urandom_range(0, 5));
    else
      seg_field = 16'(nseg);

    append_byte(scd_pkg::MAGIC_LO);
    append_byte(scd_pkg::MAGIC_HI);
    push_word(scd_pkg::FLAG_WORD);
    repeat (3) push_word(16'($urandom));
    push_word(seg_field);

    if (flaw == FLAW_ORPHAN) begin
      if ($urandom_range(0, 1) != 0) push_word(scd_pkg::CODE_MARK);
      else append_byte(content_byte());
    end
    repeat (nseg) begin
      push_word(scd_pkg::SEG_MARK);
      repeat ($urandom_range(0, 4)) append_byte(content_byte());
      if ($urandom_range(0, 3) != 0) begin
        push_word(scd_pkg::CODE_MARK);
        repeat ($urandom_range(0, 6)) append_byte(content_byte());
      end
    end
    push_word(scd_pkg::TRAILER_WORD);

    k = -1;
    case (flaw)
      FLAW_MAGIC:   k = $urandom_range(0, 1);
      FLAW_FLAG:    k = $urandom_range(2, 3);
      FLAW_TRAILER: k = img.size() - 1 - $urandom_range(0, 1);
      default:      k = -1;
    endcase
    if (k >= 0) img[k] = img[k] ^ (8'h01 << $urandom_range(0, 7));

    csum = '0;
    foreach (img[i]) csum = csum + {8'h00, img[i]};
    if (flaw == FLAW_CHECKSUM) csum = csum ^ 16'($urandom_range(1, 16'hFFFF));
    push_word(csum);
  endtask

  task automatic send_beat(input logic [7:0] b, input logic last);
    int gap;
    gap = tx_fast ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid        = 1'b1;
    in_data.in_byte = b;
    in_data.in_last = last;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_image();
    foreach (img[i]) send_beat(img[i], i == img.size() - 1);
  endtask

  task automatic drain_results();
    in_valid = 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  // result side: random stall before each beat, with fast stretches
  initial begin
    int stall;
    out_ready = 1'b0;
    rx_fast   = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) rx_fast = !rx_fast;
      stall = rx_fast ? 0 : $urandom_range(0, 12);
      if (stall > 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n !== 1'b1 || (in_valid && in_ready) || (out_valid && out_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  initial begin
    int n_img;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    tx_fast    = 1'b0;
    bytes_sent = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // smallest legal image: no segments, extreme header fields
    img.delete();
    append_byte(scd_pkg::MAGIC_LO);
    append_byte(scd_pkg::MAGIC_HI);
    push_word(scd_pkg::FLAG_WORD);
    push_word(16'hFFFF);
    push_word(16'h0000);
    push_word(16'h8001);
    push_word(16'h0000);
    push_word(scd_pkg::TRAILER_WORD);
    begin
      logic [15:0] s;
      s = '0;
      foreach (img[i]) s = s + {8'h00, img[i]};
      push_word(s);
    end
    tx_fast = 1'b1;
    send_image();
    // one-beat image, then a three-beat one
    tx_fast = 1'b0;
    send_beat(8'h00, 1'b1);
    send_beat(8'hFF, 1'b0);
    send_beat(8'h80, 1'b0);
    send_beat(8'h7F, 1'b1);
    drain_results();

    n_img = 0;
    while (bytes_sent < BYTE_TARGET) begin
      if (n_img <= FLAW_NOISE)
        build_image(flaw_e'(n_img));
      else if ($urandom_range(0, 1) == 0)
        build_image(FLAW_NONE);
      else
        build_image(flaw_e'($urandom_range(0, FLAW_NOISE)));
      tx_fast = ($urandom_range(0, 3) == 0);
      send_image();
      n_img++;
      if (n_img == 7) drain_results();
    end
    in_valid = 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (DRAIN_TAIL) @(negedge clk);

    $display("Sent %0d bytes in %0d images (%0d ok); %0d result beats checked.",
             bytes_sent, images_done, images_ok, results_seen);
    $display("Faults covered: short, magic, flag word, checksum, overflow, orphan, trailer.");
    if (fail_count == 0 && pending == 0)
      $display("tb_top: PASS");
    else
      $display("tb_top: FAIL");
    $finish;
  end

endmodule
